@@ hdl/chte_pkg.sv @@
// Shared codes for the chained hash table engine.
package chte_pkg;
   localparam logic [1:0] OP_ADD  = 2'd0;
   localparam logic [1:0] OP_FIND = 2'd1;
   localparam logic [1:0] OP_NEXT = 2'd2;
   localparam logic [1:0] OP_ENUM = 2'd3;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam int START_SLOTS = 7;
   localparam int FREE_MAX    = 4095;
   localparam int LF_RESET    = 4;
   localparam int LF_MAX      = 16;

   localparam logic CSR_LOAD_FACTOR = 1'b0;
endpackage

@@ hdl/chte_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
module chte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

@@ hdl/chte_mod.sv @@
// Bit-serial 32-bit remainder unit (restoring, one dividend bit per cycle).
module chte_mod #(
   parameter int DIV_W = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [31:0]      dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] rem
);
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic [31:0]      dvd_ff, dvd_in;
   logic [DIV_W:0]   rem_ff, rem_in;
   logic [DIV_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff[DIV_W-1:0], dvd_ff[31]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
         dvd_in = {dvd_ff[30:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff[DIV_W-1:0];
endmodule

@@ hdl/chained_hash_table_engine.sv @@
// Top level: chained hash table with bucket-head and node memories.
//
// channel  dir  handshake          payload
// req_     in   tvalid/tready      tuser: req_type; tdata: hash, data, node index
// rsp_     out  tvalid/tready      tuser: status; tdata: index, data, hash
// csr_     in   psel/penable/...   load_factor at byte address 0
//
// Find and add each run the hash through the serial remainder unit to pick the bucket.
// Find-next and enumerate read the node memory directly; one item in flight at a time.
// A doubling add clears 2*slots heads, then rehashes each stored node through the remainder unit.
// After reset or a load_factor write, a head clearing pass over the START_SLOTS heads runs.
// A result waits in the output register; a stalled rsp_ holds the engine.
module chained_hash_table_engine
   import chte_pkg::*;
#(
   parameter int MAX_NODES = 256,
   parameter int MAX_SLOTS = 448,
   parameter int DATA_W    = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // hash_value, entry_data, node_index
   input  logic [1:0]  req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // found_index, found_data, found_hash
   output logic [1:0]  rsp_tuser,   // status
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int NIW = $clog2(MAX_NODES);
   localparam int NW  = NIW + 1;
   localparam int SW  = $clog2(MAX_SLOTS + 1);
   localparam int SIW = $clog2(MAX_SLOTS);
   localparam int NDW = NW + 32 + DATA_W;
   localparam int PW  = SW + 5;
   localparam logic [NW-1:0] EMPTY = '1;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DISP  = 4'd1;
   localparam logic [3:0] S_CLEAR = 4'd2;
   localparam logic [3:0] S_RH_RD = 4'd3;
   localparam logic [3:0] S_RH_MS = 4'd4;
   localparam logic [3:0] S_RH_MW = 4'd5;
   localparam logic [3:0] S_RH_WR = 4'd6;
   localparam logic [3:0] S_ADD   = 4'd7;
   localparam logic [3:0] S_MOD   = 4'd8;
   localparam logic [3:0] S_HEAD  = 4'd9;
   localparam logic [3:0] S_LINK  = 4'd10;
   localparam logic [3:0] S_NODE  = 4'd11;
   localparam logic [3:0] S_OUT   = 4'd12;

   logic [3:0]        state_ff, state_in;
   logic [4:0]        lf_ff, lf_in;
   logic [SW-1:0]     slot_ff, slot_in;
   logic [NW-1:0]     nc_ff, nc_in;
   logic [11:0]       free_ff, free_in;
   logic [SIW-1:0]    clr_ff, clr_in;
   logic [SW-1:0]     clr_end_ff, clr_end_in;
   logic              rehash_ff, rehash_in;
   logic [NIW-1:0]    rh_ff, rh_in;
   logic [NIW-1:0]    nidx_ff, nidx_in;
   logic [1:0]        op_ff, op_in;
   logic [31:0]       hash_ff, hash_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic [7:0]        start_ff, start_in;
   logic [NDW-1:0]    nd_ff, nd_in;
   logic [1:0]        res_st_ff, res_st_in;
   logic [7:0]        res_idx_ff, res_idx_in;
   logic [31:0]       res_data_ff, res_data_in;
   logic [31:0]       res_hash_ff, res_hash_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [71:0]       rsp_data_ff, rsp_data_in;
   logic [1:0]        rsp_user_ff, rsp_user_in;

   logic              head_we;
   logic [SIW-1:0]    head_waddr, head_raddr;
   logic [NW-1:0]     head_wdata, head_rdata;
   logic              node_we;
   logic [NIW-1:0]    node_waddr, node_raddr;
   logic [NDW-1:0]    node_wdata, node_rdata;
   logic              mod_start, mod_done;
   logic [31:0]       mod_dvd;
   logic [SW-1:0]     mod_rem;
   logic [SIW-1:0]    bucket;

   logic              cfg_wr;
   logic [4:0]        cfg_lf;
   logic [PW-1:0]     prod;
   logic [11:0]       free_new;
   logic [31:0]       start_w, nc_w, head_w, link_w;
   logic [NW-1:0]     nd_link;
   logic [31:0]       nd_hash;
   logic [63:0]       nd_pay;

   chte_ram #(.WIDTH(NW), .DEPTH(MAX_SLOTS)) u_head (
      .clock(clock), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
      .raddr(head_raddr), .rdata(head_rdata));

   chte_ram #(.WIDTH(NDW), .DEPTH(MAX_NODES)) u_node (
      .clock(clock), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
      .raddr(node_raddr), .rdata(node_rdata));

   chte_mod #(.DIV_W(SW)) u_mod (
      .clock(clock), .reset(reset), .start(mod_start), .dividend(mod_dvd),
      .divisor(slot_ff), .done(mod_done), .rem(mod_rem));

   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2] == CSR_LOAD_FACTOR);
   assign csr_pready = 1'b1;
   assign csr_prdata = {27'd0, lf_ff};
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign bucket  = mod_rem[SIW-1:0];
   assign nd_link = node_rdata[NDW-1 -: NW];
   assign nd_hash = node_rdata[DATA_W +: 32];
   assign nd_pay  = 64'(node_rdata[DATA_W-1:0]);
   assign start_w = 32'(start_ff);
   assign nc_w    = 32'(nc_ff);
   assign head_w  = 32'(head_rdata);
   assign link_w  = 32'(nd_link);
   assign prod    = PW'(slot_ff) * PW'(lf_ff);
   assign free_new = (32'(prod) > 32'(FREE_MAX)) ? 12'(FREE_MAX) : 12'(prod);

   always_comb begin
      cfg_lf = csr_pwdata[4:0];
      if (cfg_lf == 5'd0) begin
         cfg_lf = 5'd1;
      end else if (cfg_lf > 5'(LF_MAX)) begin
         cfg_lf = 5'(LF_MAX);
      end
   end

   always_comb begin
      state_in    = state_ff;
      lf_in       = lf_ff;
      slot_in     = slot_ff;
      nc_in       = nc_ff;
      free_in     = free_ff;
      clr_in      = clr_ff;
      clr_end_in  = clr_end_ff;
      rehash_in   = rehash_ff;
      rh_in       = rh_ff;
      nidx_in     = nidx_ff;
      op_in       = op_ff;
      hash_in     = hash_ff;
      data_in     = data_ff;
      start_in    = start_ff;
      nd_in       = nd_ff;
      res_st_in   = res_st_ff;
      res_idx_in  = res_idx_ff;
      res_data_in = res_data_ff;
      res_hash_in = res_hash_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      head_we     = 1'b0;
      head_waddr  = clr_ff;
      head_wdata  = EMPTY;
      head_raddr  = bucket;
      node_we     = 1'b0;
      node_waddr  = rh_ff;
      node_wdata  = {head_rdata, hash_ff, data_ff};
      node_raddr  = rh_ff;
      mod_start   = 1'b0;
      mod_dvd     = hash_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser;
               hash_in  = req_tdata[31:0];
               data_in  = DATA_W'(64'(req_tdata[63:32]));
               start_in = req_tdata[71:64];
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            case (op_ff)
               OP_ADD: begin
                  if (free_ff != 12'd0) begin
                     state_in = S_ADD;
                  end else if (32'(slot_ff) * 2 > 32'(MAX_SLOTS)) begin
                     res_st_in = ST_FULL;
                     state_in  = S_OUT;
                  end else begin
                     slot_in    = SW'(32'(slot_ff) * 2);
                     free_in    = free_new;
                     clr_in     = '0;
                     clr_end_in = SW'(32'(slot_ff) * 2);
                     rehash_in  = 1'b1;
                     state_in   = S_CLEAR;
                  end
               end
               OP_FIND: begin
                  mod_start = 1'b1;
                  state_in  = S_MOD;
               end
               default: begin
                  if (start_w >= nc_w) begin
                     res_st_in = ST_MISS;
                     state_in  = S_OUT;
                  end else begin
                     node_raddr = start_w[NIW-1:0];
                     nidx_in    = start_w[NIW-1:0];
                     state_in   = (op_ff == OP_NEXT) ? S_LINK : S_NODE;
                  end
               end
            endcase
         end
         S_CLEAR: begin
            head_we = 1'b1;
            clr_in  = clr_ff + 1'b1;
            rh_in   = '0;
            if (32'(clr_ff) + 1 == 32'(clr_end_ff)) begin
               if (!rehash_ff) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = (nc_ff == '0) ? S_ADD : S_RH_RD;
               end
            end
         end
         S_RH_RD: begin
            node_raddr = rh_ff;
            state_in   = S_RH_MS;
         end
         S_RH_MS: begin
            nd_in     = node_rdata;
            mod_dvd   = nd_hash;
            mod_start = 1'b1;
            state_in  = S_RH_MW;
         end
         S_RH_MW: begin
            if (mod_done) begin
               state_in = S_RH_WR;
            end
         end
         S_RH_WR: begin
            node_we    = 1'b1;
            node_waddr = rh_ff;
            node_wdata = {head_rdata, nd_ff[DATA_W+31:0]};
            head_we    = 1'b1;
            head_waddr = bucket;
            head_wdata = NW'(rh_ff);
            rh_in      = rh_ff + 1'b1;
            if (32'(rh_ff) + 1 == nc_w) begin
               state_in = S_ADD;
            end else begin
               state_in = S_RH_RD;
            end
         end
         S_ADD: begin
            rehash_in = 1'b0;
            if (nc_w >= 32'(MAX_NODES)) begin
               res_st_in = ST_FULL;
               state_in  = S_OUT;
            end else begin
               mod_start = 1'b1;
               state_in  = S_MOD;
            end
         end
         S_MOD: begin
            if (mod_done) begin
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            if (op_ff == OP_ADD) begin
               node_we     = 1'b1;
               node_waddr  = nc_ff[NIW-1:0];
               node_wdata  = {head_rdata, hash_ff, data_ff};
               head_we     = 1'b1;
               head_waddr  = bucket;
               head_wdata  = nc_ff;
               nc_in       = nc_ff + 1'b1;
               if (free_ff != 12'd0) begin
                  free_in = free_ff - 12'd1;
               end
               res_st_in   = ST_OK;
               res_idx_in  = nc_w[7:0];
               res_data_in = 32'(64'(data_ff));
               res_hash_in = hash_ff;
               state_in    = S_OUT;
            end else if (head_w >= nc_w) begin
               res_st_in = ST_MISS;
               state_in  = S_OUT;
            end else begin
               node_raddr = head_rdata[NIW-1:0];
               nidx_in    = head_rdata[NIW-1:0];
               state_in   = S_NODE;
            end
         end
         S_LINK: begin
            if (link_w >= nc_w) begin
               res_st_in = ST_MISS;
               state_in  = S_OUT;
            end else begin
               node_raddr = nd_link[NIW-1:0];
               nidx_in    = nd_link[NIW-1:0];
               state_in   = S_NODE;
            end
         end
         S_NODE: begin
            res_st_in   = ST_OK;
            res_idx_in  = 8'(32'(nidx_ff));
            res_data_in = nd_pay[31:0];
            res_hash_in = nd_hash;
            state_in    = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = res_st_ff;
               if (res_st_ff == ST_OK) begin
                  rsp_data_in = {res_hash_ff, res_data_ff, res_idx_ff};
               end else begin
                  rsp_data_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (cfg_wr) begin
         lf_in      = cfg_lf;
         slot_in    = SW'(START_SLOTS);
         nc_in      = '0;
         free_in    = 12'(32'(START_SLOTS) * 32'(cfg_lf));
         clr_in     = '0;
         clr_end_in = SW'(START_SLOTS);
         rehash_in  = 1'b0;
         state_in   = S_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         lf_ff        <= 5'(LF_RESET);
         slot_ff      <= SW'(START_SLOTS);
         nc_ff        <= '0;
         free_ff      <= 12'(START_SLOTS * LF_RESET);
         clr_ff       <= '0;
         clr_end_ff   <= SW'(START_SLOTS);
         rehash_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lf_ff        <= lf_in;
         slot_ff      <= slot_in;
         nc_ff        <= nc_in;
         free_ff      <= free_in;
         clr_ff       <= clr_in;
         clr_end_ff   <= clr_end_in;
         rehash_ff    <= rehash_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rh_ff       <= rh_in;
      nidx_ff     <= nidx_in;
      op_ff       <= op_in;
      hash_ff     <= hash_in;
      data_ff     <= data_in;
      start_ff    <= start_in;
      nd_ff       <= nd_in;
      res_st_ff   <= res_st_in;
      res_idx_ff  <= res_idx_in;
      res_data_ff <= res_data_in;
      res_hash_ff <= res_hash_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end
endmodule
